FILE: sv/afr_pkg.sv
// Shared types and constants for the alpha fade ramp.
// Used by afr_divider and alpha_fade_ramp; depends on nothing else.

package afr_pkg;

   // time fields and alpha
   localparam int TIME_BITS  = 16;
   localparam int ALPHA_BITS = 8;
   localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = 8'd255;

   // product of an alpha-sized factor and a time, and the divider built on it
   localparam int PROD_BITS  = ALPHA_BITS + TIME_BITS;
   localparam int DIV_CNT_BITS = $clog2(PROD_BITS);

   // stream packing
   localparam int REQ_DATA_BITS = 40;  // fade_dir, duration, delta_time, padded
   localparam int RSP_DATA_BITS = 16;  // alpha_out, fade_state, padded

   // command codes carried in tuser
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // fade direction codes
   localparam logic [1:0] DIR_IDLE = 2'd0;
   localparam logic [1:0] DIR_IN   = 2'd1;
   localparam logic [1:0] DIR_OUT  = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_LOAD,
      S_DIV,
      S_RESP
   } afr_state_type;

endpackage

FILE: sv/alpha_fade_ramp.sv
// Linear alpha fade controller: top level with sequencer and fade state.
// Depends on afr_pkg and instantiates afr_divider.

// Each request transfer is either a start (tuser low) with a direction and
// duration, or a tick (tuser high) with a time delta; every request yields
// exactly one response transfer carrying the alpha and fade state after it.
// The block takes one request at a time and is not ready until that request's
// response has been placed in the output register. Requests that need no
// division (ignored starts, starts that land on the end value at once, idle
// ticks, ticks that finish the fade) pass from the accept through S_SETUP to
// S_RESP, which registers the response. Starts that resume a fade and ticks
// inside a fade run one 8x16 multiply and then the shared restoring divider,
// which retires one quotient bit per cycle over 24 bits, passing through
// S_SETUP, S_LOAD and S_DIV before S_RESP registers the response. A response
// that waits for rsp_tready holds the sequencer until it is taken.

module alpha_fade_ramp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] fade_dir, [17:2] duration, [33:18] delta_time, [39:34] zero
   input  logic [afr_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [0] cmd
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] alpha_out, [9:8] fade_state, [15:10] zero
   output logic [afr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import afr_pkg::*;

   afr_state_type              state_ff, state_in;
   logic                       div_start;
   logic                       div_done;

   // captured request
   logic                       cmd_ff, cmd_in;
   logic [1:0]                 dir_ff, dir_in;
   logic [TIME_BITS-1:0]       dur_ff, dur_in;
   logic [TIME_BITS-1:0]       dt_ff, dt_in;

   // fade state
   logic [ALPHA_BITS-1:0]      alpha_ff, alpha_in;
   logic [1:0]                 direction_ff, direction_in;
   logic [TIME_BITS-1:0]       fade_length_ff, fade_length_in;
   logic [TIME_BITS-1:0]       elapsed_ff, elapsed_in;

   // divider operands
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic [TIME_BITS-1:0]       divisor_ff, divisor_in;
   logic [PROD_BITS-1:0]       quotient;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ALPHA_BITS-1:0]      rsp_alpha_ff, rsp_alpha_in;
   logic [1:0]                 rsp_state_ff, rsp_state_in;

   // setup decode
   logic [TIME_BITS:0]         sum;
   logic [TIME_BITS-1:0]       rest;
   logic [ALPHA_BITS-1:0]      mul_a;
   logic [TIME_BITS-1:0]       mul_b;
   logic [TIME_BITS-1:0]       div_by;
   logic                       early;
   logic                       fading;
   logic                       accept;
   logic                       rsp_load;

   assign accept = req_tvalid && req_tready;

   // pick the multiply and divide operands, or flag an item that ends at once
   always_comb begin
      sum    = {1'b0, elapsed_ff} + {1'b0, dt_ff};
      rest   = fade_length_ff - sum[TIME_BITS-1:0];
      fading = (direction_ff == DIR_IN) || (direction_ff == DIR_OUT);
      mul_a  = ALPHA_MAX;
      mul_b  = dur_ff;
      div_by = TIME_BITS'(ALPHA_MAX);
      early  = 1'b1;
      if (cmd_ff == CMD_START) begin
         unique case (dir_ff)
            DIR_IN: begin
               mul_a = alpha_ff;
               early = (alpha_ff == ALPHA_MAX) || (dur_ff == '0);
            end
            DIR_OUT: begin
               mul_a = ALPHA_MAX - alpha_ff;
               early = (alpha_ff == '0) || (dur_ff == '0);
            end
            default: early = 1'b1;
         endcase
      end else begin
         mul_b  = (direction_ff == DIR_IN) ? sum[TIME_BITS-1:0] : rest;
         div_by = fade_length_ff;
         early  = !fading || (sum >= {1'b0, fade_length_ff});
      end
   end

   // next values of the captured request, fade state and operands
   always_comb begin
      cmd_in         = cmd_ff;
      dir_in         = dir_ff;
      dur_in         = dur_ff;
      dt_in          = dt_ff;
      alpha_in       = alpha_ff;
      direction_in   = direction_ff;
      fade_length_in = fade_length_ff;
      elapsed_in     = elapsed_ff;
      prod_in        = prod_ff;
      divisor_in     = divisor_ff;
      if (accept) begin
         cmd_in = req_tuser;
         dir_in = req_tdata[1:0];
         dur_in = req_tdata[2 +: TIME_BITS];
         dt_in  = req_tdata[2 + TIME_BITS +: TIME_BITS];
      end
      if (state_ff == S_SETUP) begin
         prod_in    = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
         divisor_in = div_by;
         if (cmd_ff == CMD_START) begin
            // jump straight to the end value
            if (early && dir_ff == DIR_IN) begin
               alpha_in       = ALPHA_MAX;
               direction_in   = DIR_IDLE;
               fade_length_in = '0;
            end else if (early && dir_ff == DIR_OUT) begin
               alpha_in       = '0;
               direction_in   = DIR_IDLE;
               fade_length_in = '0;
            end
         end else if (fading) begin
            if (early) begin
               // finish the fade
               alpha_in       = (direction_ff == DIR_IN) ? ALPHA_MAX : '0;
               direction_in   = DIR_IDLE;
               fade_length_in = '0;
               elapsed_in     = '0;
            end else begin
               elapsed_in = sum[TIME_BITS-1:0];
            end
         end
      end
      if (state_ff == S_DIV && div_done) begin
         if (cmd_ff == CMD_START) begin
            // resume from the point of the ramp that matches alpha
            elapsed_in     = quotient[TIME_BITS-1:0];
            fade_length_in = dur_ff;
            direction_in   = dir_ff;
         end else begin
            alpha_in = quotient[ALPHA_BITS-1:0];
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_SETUP;
         S_SETUP: state_in = early ? S_RESP : S_LOAD;
         S_LOAD:  state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_RESP;
         S_RESP:  if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_LOAD:  div_start = 1'b1;
         S_RESP:  rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // response register: load the new result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_state_in = rsp_state_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_alpha_in = alpha_ff;
         rsp_state_in = direction_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   afr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         alpha_ff       <= ALPHA_MAX;
         direction_ff   <= DIR_IDLE;
         fade_length_ff <= '0;
         elapsed_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         alpha_ff       <= alpha_in;
         direction_ff   <= direction_in;
         fade_length_ff <= fade_length_in;
         elapsed_ff     <= elapsed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      dir_ff       <= dir_in;
      dur_ff       <= dur_in;
      dt_ff        <= dt_in;
      prod_ff      <= prod_in;
      divisor_ff   <= divisor_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_state_ff <= rsp_state_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - ALPHA_BITS - 2){1'b0}}, rsp_state_ff, rsp_alpha_ff};

   // an idle fade keeps no length
   a_idle_no_length: assert property (@(posedge clock) disable iff (reset)
      direction_ff == DIR_IDLE |-> fade_length_ff == '0)
      else $error("idle with a nonzero fade length");

   // inside a fade, elapsed time stays short of the length
   a_elapsed_bound: assert property (@(posedge clock) disable iff (reset)
      direction_ff != DIR_IDLE |-> elapsed_ff < fade_length_ff)
      else $error("elapsed time reached the fade length");

   // the divider only reports back while the sequencer waits for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider done outside the divide state");

   // a response is loaded only from the response state
   a_load_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_RESP)
      else $error("response raised outside the response state");

endmodule

FILE: sv/afr_divider.sv
// Restoring divider for the alpha fade ramp, one quotient bit per cycle.
// Depends on afr_pkg for widths and the counter size.

module afr_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [afr_pkg::PROD_BITS-1:0]       dividend,
   input  logic [afr_pkg::TIME_BITS-1:0]       divisor,
   output logic                                done,
   output logic [afr_pkg::PROD_BITS-1:0]       quotient
);
   import afr_pkg::*;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DIV_CNT_BITS-1:0]    count_ff, count_in;
   logic [TIME_BITS-1:0]       rem_ff, rem_in;
   logic [TIME_BITS-1:0]       divisor_ff, divisor_in;
   logic [PROD_BITS-1:0]       quo_ff, quo_in;
   logic [TIME_BITS:0]         shifted;
   logic [TIME_BITS+1:0]       diff;
   logic                       fits;

   // trial subtract of the divisor from the shifted remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[PROD_BITS-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor_ff};
      fits    = !diff[TIME_BITS+1];
   end

   // load on start, then shift one dividend bit in per cycle
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
         quo_in   = {quo_ff[PROD_BITS-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_BITS'(PROD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // a new division never cuts into a running one
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");

   // the sequencer never asks for a division by zero
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      start |-> divisor != '0) else $error("divide by zero requested");

   // the partial remainder stays below the divisor throughout
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < divisor_ff) else $error("remainder out of range");

   // done only closes a running division
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without a division");

endmodule

FILE: bench/afr_fade_monitor.sv
`timescale 1ns / 100ps
// Watches both streams of alpha_fade_ramp, predicts each response and compares it.
// Depends on afr_pkg; instantiated next to the block by tb_alpha_fade_ramp.

module afr_fade_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // [1:0] fade_dir, [17:2] duration, [33:18] delta_time, [39:34] zero
   input  logic [afr_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // [0] cmd
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] alpha_out, [9:8] fade_state, [15:10] zero
   input  logic [afr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output int                                  fail_count,
   output int                                  pending
);

   import afr_pkg::*;

   typedef struct {
      logic [ALPHA_BITS-1:0] alpha;
      logic [1:0]            fade_state;
   } fade_result_type;

   // predicted fade state
   logic [ALPHA_BITS-1:0] alpha_r;
   logic [1:0]            dir_r;
   logic [TIME_BITS-1:0]  fade_len_r;
   logic [TIME_BITS-1:0]  elapsed_r;

   fade_result_type expected_fade_q[$];

   // print one line per mismatch and count it
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      fail_count = fail_count + 1;
   endtask

   // advance the predicted fade by one request
   task automatic apply_fade_item(input logic cmd, input logic [1:0] dir,
                                  input logic [TIME_BITS-1:0] dur,
                                  input logic [TIME_BITS-1:0] dt);
      logic [TIME_BITS:0]   sum;
      logic [PROD_BITS-1:0] prod;
      if (cmd == CMD_START) begin
         if (dir == DIR_IN) begin
            if (alpha_r == ALPHA_MAX || dur == '0) begin
               alpha_r    = ALPHA_MAX;
               dir_r      = DIR_IDLE;
               fade_len_r = '0;
            end else begin
               // resume from the matching point of the ramp
               prod       = PROD_BITS'(alpha_r) * PROD_BITS'(dur);
               fade_len_r = dur;
               elapsed_r  = TIME_BITS'(prod / PROD_BITS'(ALPHA_MAX));
               dir_r      = DIR_IN;
            end
         end else if (dir == DIR_OUT) begin
            if (alpha_r == '0 || dur == '0) begin
               alpha_r    = '0;
               dir_r      = DIR_IDLE;
               fade_len_r = '0;
            end else begin
               prod       = PROD_BITS'(ALPHA_MAX - alpha_r) * PROD_BITS'(dur);
               fade_len_r = dur;
               elapsed_r  = TIME_BITS'(prod / PROD_BITS'(ALPHA_MAX));
               dir_r      = DIR_OUT;
            end
         end
      end else if (dir_r == DIR_IN || dir_r == DIR_OUT) begin
         // full-width sum, so a large delta never wraps below the length
         sum = (TIME_BITS+1)'(elapsed_r) + (TIME_BITS+1)'(dt);
         if (sum >= (TIME_BITS+1)'(fade_len_r)) begin
            alpha_r    = (dir_r == DIR_IN) ? ALPHA_MAX : '0;
            fade_len_r = '0;
            elapsed_r  = '0;
            dir_r      = DIR_IDLE;
         end else begin
            elapsed_r = TIME_BITS'(sum);
            if (dir_r == DIR_IN)
               prod = PROD_BITS'(ALPHA_MAX) * PROD_BITS'(elapsed_r);
            else
               prod = PROD_BITS'(ALPHA_MAX) * PROD_BITS'(fade_len_r - elapsed_r);
            alpha_r = ALPHA_BITS'(prod / PROD_BITS'(fade_len_r));
         end
      end
   endtask

   // compare responses first, then predict from the request of the same edge
   always @(posedge clock) begin : watch
      fade_result_type want;
      fade_result_type got;
      if (reset) begin
         alpha_r    = ALPHA_MAX;
         dir_r      = DIR_IDLE;
         fade_len_r = '0;
         elapsed_r  = '0;
         expected_fade_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.alpha      = rsp_tdata[7:0];
            got.fade_state = rsp_tdata[9:8];
            if (expected_fade_q.size() == 0) begin
               report_mismatch("response with none expected, alpha", int'(got.alpha), 0);
            end else begin
               want = expected_fade_q.pop_front();
               if (got.alpha !== want.alpha)
                  report_mismatch("alpha_out", int'(got.alpha), int'(want.alpha));
               if (got.fade_state !== want.fade_state)
                  report_mismatch("fade_state", int'(got.fade_state),
                                  int'(want.fade_state));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_fade_item(req_tuser, req_tdata[1:0], req_tdata[17:2], req_tdata[33:18]);
            want.alpha      = alpha_r;
            want.fade_state = dir_r;
            expected_fade_q.push_back(want);
         end
      end
      pending <= expected_fade_q.size();
   end

endmodule

FILE: bench/tb_alpha_fade_ramp.sv
`timescale 1ns / 100ps
// Top of the alpha_fade_ramp bench: clock, reset, request stimulus, response stalls.
// Depends on afr_pkg, alpha_fade_ramp and afr_fade_monitor.

module tb_alpha_fade_ramp;

   import afr_pkg::*;

   localparam int ITEM_TARGET  = 750;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 400;
   localparam logic [1:0] DIR_UNUSED = 2'd3;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_MOSTLY} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int burst_left  = 0;
   int counted     = 0;
   int hold_cycles = 0;

   always #6 clock = ~clock;

   alpha_fade_ramp DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   afr_fade_monitor u_fade_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("** alpha_fade_ramp: FAILED **");
         $finish;
      end
   end

   // offer one request in bursts with random gaps, hold until the transfer
   task automatic send_item(input logic cmd, input logic [1:0] dir,
                            input logic [15:0] dur, input logic [15:0] dt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, dt, dur, dir};
      do @(posedge clock); while (!req_tready);
      if (!(cmd == CMD_START && (dir == DIR_IDLE || dir == DIR_UNUSED)))
         counted = counted + 1;
   endtask

   // stop offering and wait until every response has come back
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      wait (pending == 0);
   endtask

   // response side: stall on a pattern that changes mode now and then
   initial begin : receiver
      rx_mode_type mode;
      int mode_left;
      int stall_left;
      int phase;
      int period;
      rsp_tready = 1'b0;
      mode_left  = 0;
      stall_left = 0;
      phase      = 0;
      period     = 2;
      mode       = RX_ALWAYS;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            stall_left  = hold_cycles;
            hold_cycles = 0;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
            period    = $urandom_range(2, 8);
         end
         mode_left = mode_left - 1;
         phase     = phase + 1;
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RX_ALWAYS:  rsp_tready <= 1'b1;
               RX_RANDOM:  rsp_tready <= 1'($urandom_range(0, 1));
               RX_PATTERN: rsp_tready <= (phase % period) == 0;
               default:    rsp_tready <= $urandom_range(0, 6) != 0;
            endcase
         end
      end
   end

   // request side and verdict
   initial begin : stimulus
      logic [1:0]  dir;
      logic [15:0] dur;
      logic [15:0] dt;
      int n_ticks;
      int next_hold;
      bit drained;
      req_tvalid = 1'b0;
      req_tuser  = CMD_START;
      req_tdata  = '0;
      reset      = 1'b1;
      next_hold  = 200;
      drained    = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick, ignored starts, immediate ends, edge durations
      send_item(CMD_TICK,  DIR_OUT,    16'hFFFF, 16'hFFFF);
      send_item(CMD_START, DIR_IN,     16'd100,  16'h0000);
      send_item(CMD_START, DIR_IDLE,   16'h1234, 16'hFFFF);
      send_item(CMD_START, DIR_UNUSED, 16'hFFFF, 16'hFFFF);
      send_item(CMD_START, DIR_OUT,    16'd0,    16'h0000);
      send_item(CMD_START, DIR_OUT,    16'd100,  16'h0000);
      send_item(CMD_START, DIR_IN,     16'hFFFF, 16'h0000);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'd0);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'd1);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'h7FFF);
      // sum exceeds 16 bits and must still finish the fade
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'hFFFF);
      send_item(CMD_START, DIR_OUT,    16'd1,    16'h0000);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'd0);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'd1);
      send_item(CMD_START, DIR_IN,     16'd300,  16'h0000);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'd150);
      // reverse mid-fade: resume from the current alpha
      send_item(CMD_START, DIR_OUT,    16'd1000, 16'h0000);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'd10);
      send_item(CMD_START, DIR_IN,     16'd0,    16'h0000);
      send_item(CMD_START, DIR_OUT,    16'hFFFF, 16'h0000);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'hFFFE);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'hFFFF);
      send_item(CMD_START, DIR_IN,     16'h8000, 16'h0000);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'h1234);
      send_item(CMD_TICK,  DIR_IDLE,   16'h0000, 16'hFFFF);

      // random: mostly fades with ticks, some reversals, some noise
      while (counted < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 1)
               send_item(CMD_START, $urandom_range(0, 1) ? DIR_IDLE : DIR_UNUSED,
                         16'($urandom), 16'($urandom));
            else
               send_item(CMD_TICK, 2'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            dir = $urandom_range(0, 1) ? DIR_IN : DIR_OUT;
            case ($urandom_range(0, 9))
               7, 8:    dur = 16'($urandom_range(301, 4000));
               9:       dur = 16'($urandom);
               default: dur = 16'($urandom_range(1, 300));
            endcase
            if ($urandom_range(0, 19) == 0)
               dur = '0;
            send_item(CMD_START, dir, dur, 16'($urandom));
            n_ticks = $urandom_range(1, 12);
            repeat (n_ticks) begin
               case ($urandom_range(0, 9))
                  0:       dt = '0;
                  1:       dt = 16'($urandom);
                  default: dt = 16'($urandom_range(0, int'(dur) / 4 + 1));
               endcase
               if ($urandom_range(0, 11) == 0) begin
                  dir = (dir == DIR_IN) ? DIR_OUT : DIR_IN;
                  send_item(CMD_START, dir, 16'($urandom_range(1, 2000)), 16'($urandom));
               end
               send_item(CMD_TICK, 2'($urandom), 16'($urandom), dt);
            end
         end
         // long response stall while requests keep coming
         if (counted >= next_hold) begin
            hold_cycles = LONG_HOLD;
            next_hold   = next_hold + 320;
         end
         if (counted >= 360 && !drained) begin
            drain_responses();
            drained = 1'b1;
         end
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** alpha_fade_ramp: PASSED **");
      else
         $display("** alpha_fade_ramp: FAILED **");
      $finish;
   end

endmodule
